### hdl/pfd_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the Playfair pair decryption block.
// No dependencies; every other file of the block imports this package.
package pfd_pkg;

    localparam int SQUARE_SIDE_DEF = 6;
    localparam int KEY_ENTRIES     = 36;
    localparam int ENTRIES_PER_REG = 8;
    localparam int CHAR_W          = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h78;

    typedef logic [KEY_ENTRIES-1:0][CHAR_W-1:0] t_cells;

endpackage

### hdl/pfd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input characters, the results and
// the key square writes. Depends on pfd_pkg.
interface pfd_in_if import pfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink (input valid, input in_char, input end_of_text, output ready);
endinterface

interface pfd_out_if import pfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last_of_pair;
    logic              not_in_square;

    modport source (output valid, output out_char, output last_of_pair,
                    output not_in_square, input ready);
    modport sink (input valid, input out_char, input last_of_pair,
                  input not_in_square, output ready);
endinterface

interface pfd_cfg_if import pfd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/pfd_front.sv
`timescale 1ns / 1ps
// Front end: key square registers, character pairing and location lookup.
// Depends on pfd_pkg and pfd_if; feeds located pairs to pfd_queue.
module pfd_front import pfd_pkg::*; #(
    parameter int SQUARE_SIDE = SQUARE_SIDE_DEF,
    parameter int POS_W       = $clog2(SQUARE_SIDE),
    parameter int PAIR_W      = 2 * CHAR_W + 1 + 4 * POS_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pfd_in_if.sink            i_in,
    pfd_cfg_if.sink           i_cfg,
    output t_cells            o_cells,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output logic [PAIR_W-1:0] o_push_data
);

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_loc;

    typedef struct packed {
        logic [CHAR_W-1:0] a;
        logic [CHAR_W-1:0] b;
        logic              miss;
        logic [POS_W-1:0]  r1;
        logic [POS_W-1:0]  c1;
        logic [POS_W-1:0]  r2;
        logic [POS_W-1:0]  c2;
    } t_pair;

    t_cells            r_cells;
    logic [CHAR_W-1:0] r_held_char;
    t_loc              r_held_loc;
    logic              r_have_held;

    t_loc  cur_loc;
    t_loc  pad_loc;
    t_pair pair;
    logic  accept;

    // The scan runs from the last cell down so that the first match wins.
    function automatic t_loc locate(input t_cells cells, input logic [CHAR_W-1:0] ch);
        t_loc l;
        l = '0;
        for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
            for (int c = SQUARE_SIDE - 1; c >= 0; c--) begin
                if (cells[r * SQUARE_SIDE + c] == ch) begin
                    l.found = 1'b1;
                    l.row   = POS_W'(r);
                    l.col   = POS_W'(c);
                end
            end
        end
        return l;
    endfunction

    assign cur_loc = locate(r_cells, i_in.in_char);
    assign pad_loc = locate(r_cells, PAD_CHAR);

    assign i_in.ready  = i_push_ready;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_push_ready;

    always_comb begin
        if (r_have_held) begin
            pair.a    = r_held_char;
            pair.b    = i_in.in_char;
            pair.miss = !(r_held_loc.found && cur_loc.found);
            pair.r1   = r_held_loc.row;
            pair.c1   = r_held_loc.col;
            pair.r2   = cur_loc.row;
            pair.c2   = cur_loc.col;
        end else begin
            pair.a    = i_in.in_char;
            pair.b    = PAD_CHAR;
            pair.miss = !(cur_loc.found && pad_loc.found);
            pair.r1   = cur_loc.row;
            pair.c1   = cur_loc.col;
            pair.r2   = pad_loc.row;
            pair.c2   = pad_loc.col;
        end
    end

    assign o_push_valid = i_in.valid && (r_have_held || i_in.end_of_text);
    assign o_push_data  = pair;
    assign o_cells      = r_cells;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= '0;
        end else if (i_cfg.valid) begin
            for (int e = 0; e < KEY_ENTRIES; e++) begin
                if (i_cfg.index == CFG_IDX_W'(e / ENTRIES_PER_REG)) begin
                    r_cells[e] <= i_cfg.data[(e % ENTRIES_PER_REG) * CHAR_W +: CHAR_W];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_held <= 1'b0;
            r_held_char <= '0;
        end else if (accept) begin
            if (r_have_held) begin
                r_have_held <= 1'b0;
                r_held_char <= '0;
            end else if (!i_in.end_of_text) begin
                r_have_held <= 1'b1;
                r_held_char <= i_in.in_char;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_have_held) begin
            r_held_loc <= cur_loc;
        end
    end

endmodule

### hdl/pfd_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue that decouples the front end from the
// back end. Depends on pfd_pkg for its depth.
module pfd_queue import pfd_pkg::*; #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/pfd_back.sv
`timescale 1ns / 1ps
// Back end: applies the Playfair decryption rule to a located pair and
// sends its two result characters. Depends on pfd_pkg and pfd_if.
module pfd_back import pfd_pkg::*; #(
    parameter int SQUARE_SIDE = SQUARE_SIDE_DEF,
    parameter int POS_W       = $clog2(SQUARE_SIDE),
    parameter int PAIR_W      = 2 * CHAR_W + 1 + 4 * POS_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cells            i_cells,
    input  logic              i_pop_valid,
    output logic              o_pop_ready,
    input  logic [PAIR_W-1:0] i_pop_data,
    pfd_out_if.source         o_out
);

    typedef struct packed {
        logic [CHAR_W-1:0] a;
        logic [CHAR_W-1:0] b;
        logic              miss;
        logic [POS_W-1:0]  r1;
        logic [POS_W-1:0]  c1;
        logic [POS_W-1:0]  r2;
        logic [POS_W-1:0]  c2;
    } t_pair;

    t_pair             pair;
    logic [POS_W-1:0]  n_r1;
    logic [POS_W-1:0]  n_c1;
    logic [POS_W-1:0]  n_r2;
    logic [POS_W-1:0]  n_c2;
    logic [CHAR_W-1:0] sel1;
    logic [CHAR_W-1:0] sel2;
    logic              take;

    logic              r_busy;
    logic              r_second;
    logic [CHAR_W-1:0] r_o1;
    logic [CHAR_W-1:0] r_o2;
    logic              r_miss;

    function automatic logic [POS_W-1:0] step_back(input logic [POS_W-1:0] v);
        return (v == '0) ? POS_W'(SQUARE_SIDE - 1) : v - 1'b1;
    endfunction

    assign pair = i_pop_data;

    always_comb begin
        n_r1 = pair.r1;
        n_c1 = pair.c1;
        n_r2 = pair.r2;
        n_c2 = pair.c2;
        if (pair.r1 == pair.r2 && pair.c1 == pair.c2) begin
            n_r1 = pair.r1;
        end else if (pair.r1 == pair.r2) begin
            n_c1 = step_back(pair.c1);
            n_c2 = step_back(pair.c2);
        end else if (pair.c1 == pair.c2) begin
            n_r1 = step_back(pair.r1);
            n_r2 = step_back(pair.r2);
        end else begin
            n_c1 = pair.c2;
            n_c2 = pair.c1;
        end
    end

    always_comb begin
        sel1 = '0;
        sel2 = '0;
        for (int r = 0; r < SQUARE_SIDE; r++) begin
            for (int c = 0; c < SQUARE_SIDE; c++) begin
                if (n_r1 == POS_W'(r) && n_c1 == POS_W'(c)) begin
                    sel1 = sel1 | i_cells[r * SQUARE_SIDE + c];
                end
                if (n_r2 == POS_W'(r) && n_c2 == POS_W'(c)) begin
                    sel2 = sel2 | i_cells[r * SQUARE_SIDE + c];
                end
            end
        end
    end

    assign take        = !r_busy || (r_second && o_out.ready);
    assign o_pop_ready = take;

    assign o_out.valid         = r_busy;
    assign o_out.out_char      = r_second ? r_o2 : r_o1;
    assign o_out.last_of_pair  = r_second;
    assign o_out.not_in_square = r_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (r_busy && o_out.ready) begin
                r_busy   <= !r_second;
                r_second <= !r_second;
            end
            if (i_pop_valid && take) begin
                r_busy   <= 1'b1;
                r_second <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop_valid && take) begin
            r_o1   <= pair.miss ? pair.a : sel1;
            r_o2   <= pair.miss ? pair.b : sel2;
            r_miss <= pair.miss;
        end
    end

endmodule

### hdl/playfair_pair_decrypt_top.sv
`timescale 1ns / 1ps
// Playfair pair decryption top level: front end, pair queue and back end.
// Throughput: one character accepted per cycle unless the pair queue is full; results
// leave at one per cycle while the output port is ready. A closing character's pair
// passes through the pair queue and the back end's output registers before its first
// result is valid; the second result follows once the first transfers, and the output
// port sets the pace. Synchronous active-low reset clears the key square to zero,
// drops any held character and empties the queue. Depends on pfd_pkg, pfd_if.
module playfair_pair_decrypt_top import pfd_pkg::*; #(
    parameter int SQUARE_SIDE = SQUARE_SIDE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfd_in_if.sink    i_in,
    pfd_cfg_if.sink   i_cfg,
    pfd_out_if.source o_out
);

    localparam int POS_W  = $clog2(SQUARE_SIDE);
    localparam int PAIR_W = 2 * CHAR_W + 1 + 4 * POS_W;

    t_cells            cells;
    logic              push_valid;
    logic              push_ready;
    logic [PAIR_W-1:0] push_data;
    logic              pop_valid;
    logic              pop_ready;
    logic [PAIR_W-1:0] pop_data;

    pfd_front #(
        .SQUARE_SIDE (SQUARE_SIDE),
        .POS_W       (POS_W),
        .PAIR_W      (PAIR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_cells      (cells),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    pfd_queue #(
        .WIDTH (PAIR_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    pfd_back #(
        .SQUARE_SIDE (SQUARE_SIDE),
        .POS_W       (POS_W),
        .PAIR_W      (PAIR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cells     (cells),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out       (o_out)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for playfair_pair_decrypt_top: directed pairs, then random text
// under several key squares, checked result by result against an in-bench decipher model.
// Depends on pfd_pkg, the pfd interfaces and the playfair_pair_decrypt_top RTL.
module tb_top;
    import pfd_pkg::*;

    localparam int SIDE          = SQUARE_SIDE_DEF;
    localparam int CELLS         = SIDE * SIDE;
    localparam int DIR_ROWS      = 24;
    localparam int FIRST_KEYED   = 5;
    localparam int SWEEPS        = 6;
    localparam int SWEEP_CHARS   = 125;
    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3, REG_KEY4,
        REG_SPARE5, REG_SPARE6, REG_SPARE7
    } t_key_reg;

    typedef enum int {SQ_DIRECTED, SQ_DISTINCT, SQ_REPEATS, SQ_ALL_ONES, SQ_ALL_ZERO}
        t_square_kind;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_of_pair;
        logic              not_in_square;
    } t_result;

    typedef struct {
        logic [CHAR_W-1:0] in_char;
        logic              end_of_text;
        bit                typed;
        t_result           exp_first;
        t_result           exp_second;
    } t_row;

    localparam t_result NO_RES = '0;

    // The key square starts out all zero, so a pair of zero bytes decodes as one cell.
    t_row directed_rows [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0}},
        '{8'hFF, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h00, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b1}, '{8'h00, 1'b1, 1'b1}},
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}, '{8'h78, 1'b1, 1'b1}},
        '{8'h61, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h63, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h60, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h65, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h62, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h80, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h67, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h7C, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h6A, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h6A, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h83, 1'b1, 1'b0, NO_RES, NO_RES},
        '{8'h70, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h71, 1'b1, 1'b0, NO_RES, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h61, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b1}, '{8'h61, 1'b1, 1'b1}},
        '{8'h78, 1'b1, 1'b1, '{8'h78, 1'b0, 1'b0}, '{8'h78, 1'b1, 1'b0}},
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}, '{8'h78, 1'b1, 1'b1}},
        '{8'h7F, 1'b0, 1'b0, NO_RES, NO_RES},
        '{8'h67, 1'b1, 1'b0, NO_RES, NO_RES}
    };

    t_square_kind sweep_kinds [SWEEPS] = '{
        SQ_DISTINCT, SQ_REPEATS, SQ_ALL_ONES, SQ_DISTINCT, SQ_DISTINCT, SQ_ALL_ZERO
    };

    logic i_clk;
    logic i_rst_n;

    pfd_in_if  in_ch ();
    pfd_out_if out_ch ();
    pfd_cfg_if cfg_ch ();

    playfair_pair_decrypt_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    logic [CFG_DATA_W-1:0] key_word [5];
    logic [CHAR_W-1:0]     held_char;
    bit                    have_held;
    t_result               plain_text_q [$];

    int error_count;
    int chars_sent;
    int results_seen;
    int pairs_decoded;
    int pairs_flagged;
    int squares_loaded;
    int sender_idle_pct;
    int receiver_idle_pct;
    int long_hold_left;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [CHAR_W-1:0] square_cell(input int e);
        return key_word[e / ENTRIES_PER_REG][8 * (e % ENTRIES_PER_REG) +: 8];
    endfunction

    function automatic bit locate_char(input logic [CHAR_W-1:0] ch, output int row,
                                       output int col);
        bit found;
        found = 1'b0;
        row = 0;
        col = 0;
        for (int e = 0; e < CELLS; e++) begin
            if (!found && square_cell(e) == ch) begin
                found = 1'b1;
                row = e / SIDE;
                col = e % SIDE;
            end
        end
        return found;
    endfunction

    function automatic int wrap_back(input int v);
        return (v == 0) ? SIDE - 1 : v - 1;
    endfunction

    function automatic int decipher_char(input logic [CHAR_W-1:0] ch, input logic eot,
                                         output t_result first, output t_result second);
        logic [CHAR_W-1:0] a;
        logic [CHAR_W-1:0] b;
        int r1, c1, r2, c2, t;
        bit miss;
        if (have_held) begin
            a = held_char;
            b = ch;
            have_held = 1'b0;
            held_char = '0;
        end else if (eot) begin
            a = ch;
            b = PAD_CHAR;
        end else begin
            held_char = ch;
            have_held = 1'b1;
            return 0;
        end
        miss = !(locate_char(a, r1, c1) && locate_char(b, r2, c2));
        first.out_char = a;
        second.out_char = b;
        if (!miss) begin
            if (r1 == r2 && c1 == c2) begin
            end else if (r1 == r2) begin
                c1 = wrap_back(c1);
                c2 = wrap_back(c2);
            end else if (c1 == c2) begin
                r1 = wrap_back(r1);
                r2 = wrap_back(r2);
            end else begin
                t = c1;
                c1 = c2;
                c2 = t;
            end
            first.out_char = square_cell(r1 * SIDE + c1);
            second.out_char = square_cell(r2 * SIDE + c2);
        end
        first.last_of_pair = 1'b0;
        second.last_of_pair = 1'b1;
        first.not_in_square = miss;
        second.not_in_square = miss;
        pairs_decoded++;
        if (miss) pairs_flagged++;
        return 2;
    endfunction

    task automatic offer_char(input logic [CHAR_W-1:0] ch, input logic eot, input bit typed,
                              input t_result typed_first, input t_result typed_second);
        t_result p_first;
        t_result p_second;
        int n;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.in_char = ch;
        in_ch.end_of_text = eot;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        chars_sent++;
        n = decipher_char(ch, eot, p_first, p_second);
        if (n == 2) begin
            if (typed) begin
                p_first = typed_first;
                p_second = typed_second;
            end
            plain_text_q.push_back(p_first);
            plain_text_q.push_back(p_second);
        end
    endtask

    task automatic write_reg(input t_key_reg idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        if (idx == REG_KEY4) begin
            key_word[4] = {32'b0, value[31:0]};
        end else if (idx < REG_KEY4) begin
            key_word[idx] = value;
        end
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic program_square(input t_square_kind kind);
        logic [CHAR_W-1:0]     pool [256];
        logic [CHAR_W-1:0]     cells [CELLS];
        logic [CFG_DATA_W-1:0] words [5];
        logic [CHAR_W-1:0]     t;
        int j;
        for (int i = 0; i < 256; i++) pool[i] = CHAR_W'(i);
        for (int i = 0; i < CELLS; i++) begin
            j = $urandom_range(i, 255);
            t = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
        end
        for (int e = 0; e < CELLS; e++) begin
            case (kind)
                SQ_DIRECTED: cells[e] = CHAR_W'(8'h60 + e);
                SQ_DISTINCT: cells[e] = pool[e];
                SQ_REPEATS:  cells[e] = CHAR_W'($urandom_range(8'h30, 8'h3F));
                SQ_ALL_ONES: cells[e] = 8'hFF;
                default:     cells[e] = 8'h00;
            endcase
        end
        words[4] = {$urandom, 32'b0};
        if (kind == SQ_ALL_ONES) words[4] = '1;
        if (kind == SQ_ALL_ZERO) words[4] = '0;
        for (int e = 0; e < CELLS; e++) begin
            words[e / ENTRIES_PER_REG][8 * (e % ENTRIES_PER_REG) +: 8] = cells[e];
        end
        write_reg(REG_KEY0, words[0]);
        write_reg(REG_KEY1, words[1]);
        write_reg(REG_KEY2, words[2]);
        write_reg(REG_KEY3, words[3]);
        write_reg(REG_KEY4, words[4]);
        write_reg(REG_SPARE5, {$urandom, $urandom});
        write_reg(REG_SPARE6, {$urandom, $urandom});
        write_reg(REG_SPARE7, {$urandom, $urandom});
        squares_loaded++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (plain_text_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(99) < 85) return square_cell($urandom_range(0, CELLS - 1));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    always @(negedge i_clk) begin
        if (long_hold_left > 0) begin
            out_ch.ready = 1'b0;
            long_hold_left--;
        end else begin
            out_ch.ready = ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            results_seen++;
            got.out_char = out_ch.out_char;
            got.last_of_pair = out_ch.last_of_pair;
            got.not_in_square = out_ch.not_in_square;
            if (plain_text_q.size() == 0) begin
                $error("Result transfer with no result expected: out_char %02h", got.out_char);
                error_count++;
            end else begin
                want = plain_text_q.pop_front();
                if (got.out_char !== want.out_char) begin
                    $error("out_char: expected %02h, got %02h", want.out_char, got.out_char);
                    error_count++;
                end
                if (got.last_of_pair !== want.last_of_pair) begin
                    $error("last_of_pair: expected %0b, got %0b",
                           want.last_of_pair, got.last_of_pair);
                    error_count++;
                end
                if (got.not_in_square !== want.not_in_square) begin
                    $error("not_in_square: expected %0b, got %0b",
                           want.not_in_square, got.not_in_square);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                    || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                    || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $error("No transfer for %0d cycles, %0d results still expected",
               STALL_LIMIT, plain_text_q.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_char = '0;
        in_ch.end_of_text = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_KEY0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        for (int r = 0; r < 5; r++) key_word[r] = '0;
        held_char = '0;
        have_held = 1'b0;
        error_count = 0;
        chars_sent = 0;
        results_seen = 0;
        pairs_decoded = 0;
        pairs_flagged = 0;
        squares_loaded = 0;
        long_hold_left = 0;
        sender_idle_pct = 14;
        receiver_idle_pct = 45;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == FIRST_KEYED) begin
                wait_drained();
                program_square(SQ_DIRECTED);
            end
            offer_char(directed_rows[i].in_char, directed_rows[i].end_of_text,
                       directed_rows[i].typed, directed_rows[i].exp_first,
                       directed_rows[i].exp_second);
        end

        for (int sweep = 0; sweep < SWEEPS; sweep++) begin
            // A held first character is closed before the key square changes.
            if (have_held) offer_char(pick_char(), 1'b0, 1'b0, NO_RES, NO_RES);
            wait_drained();
            sender_idle_pct = (sweep < 2) ? 14 : (sweep < 4) ? 45 : 0;
            receiver_idle_pct = (sweep < 2) ? 45 : (sweep < 4) ? 14 : 0;
            program_square(sweep_kinds[sweep]);
            for (int n = 0; n < SWEEP_CHARS; n++) begin
                if (sweep == 4 && n == 10) long_hold_left = LONG_HOLD;
                offer_char(pick_char(), $urandom_range(99) < 8, 1'b0, NO_RES, NO_RES);
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d input characters and %0d checked result characters",
                 chars_sent, results_seen);
        $display("over %0d key squares; %0d of %0d pairs were outside the square.",
                 squares_loaded, pairs_flagged, pairs_decoded);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
